FILE: hdl/i2cram_pkg.sv
// ----------------------------------------------------------------------------
// I2C register access master: shared package
// Word types for the tick, result and configuration channels, and the
// command and register index codes used by more than one module.
// ----------------------------------------------------------------------------
package i2cram_pkg;

    localparam logic [2:0] CMD_NONE       = 3'd0;
    localparam logic [2:0] CMD_READ_BYTE  = 3'd1;
    localparam logic [2:0] CMD_READ_WORD  = 3'd2;
    localparam logic [2:0] CMD_WRITE_BYTE = 3'd3;
    localparam logic [2:0] CMD_WRITE_WORD = 3'd4;

    localparam logic CFG_DEVICE_ADDRESS = 1'b0;
    localparam logic CFG_ACK_TIMEOUT    = 1'b1;

    localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'h36;
    localparam logic [7:0] ACK_TIMEOUT_RESET    = 8'd250;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  reg_addr;
        logic [15:0] wdata;
        logic        sda_in;
    } tick_word_t;

    typedef struct packed {
        logic        scl_out;
        logic        sda_out;
        logic        busy_res;
        logic        done_res;
        logic [15:0] read_data;
        logic        ack_error;
    } res_word_t;

    typedef struct packed {
        logic [6:0] device_address;
        logic [7:0] ack_timeout;
    } cfg_t;

    // Queue head as seen by the back end: command already reduced to a
    // legal code, unknown codes become none.
    typedef struct packed {
        logic       valid;
        tick_word_t word;
    } queue_head_t;

endpackage

FILE: hdl/i2cram_front.sv
// ----------------------------------------------------------------------------
// I2C register access master: front end
// Accepts tick words, maps illegal command codes to none and holds the
// words in a two-entry queue for the bus sequencer.
// ----------------------------------------------------------------------------
module i2cram_front
    import i2cram_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        tick_valid,
    output logic        tick_stall,
    input  tick_word_t  tick_word,
    output queue_head_t head,
    input  logic        pop
);

    tick_word_t queue_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    tick_word_t classified;

    always_comb
    begin
        classified = tick_word;
        case (tick_word.cmd)
            CMD_READ_BYTE, CMD_READ_WORD, CMD_WRITE_BYTE, CMD_WRITE_WORD:
                classified.cmd = tick_word.cmd;
            default:
                classified.cmd = CMD_NONE;
        endcase
    end

    assign tick_stall = (count_reg == 2'd2);
    assign push       = tick_valid && !tick_stall;

    assign head.valid = (count_reg != 2'd0);
    assign head.word  = queue_reg[rd_ptr_reg];

    assign wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
    assign rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= classified;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != 2'd0)
        else $error("pop from empty queue");

    a_legal_head: assert property (@(posedge clk) disable iff (!rst_n)
        head.valid |-> head.word.cmd <= CMD_WRITE_WORD)
        else $error("illegal command code reached the queue head");

endmodule

FILE: hdl/i2cram_back.sv
// ----------------------------------------------------------------------------
// I2C register access master: bus sequencer
// Takes one tick word a cycle from the queue unless the result stalls, drives
// its SCL/SDA phase, advances the transfer state, registers the result word.
// ----------------------------------------------------------------------------
module i2cram_back
    import i2cram_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  queue_head_t head,
    output logic        pop,
    output logic        res_valid,
    input  logic        res_stall,
    output res_word_t   res_word
);

    typedef enum logic [4:0] {
        PH_IDLE, PH_START_HI, PH_START_LO, PH_TX_LO, PH_TX_HI,
        PH_ACK_LO, PH_ACK_HI, PH_ACK_END, PH_RS_LO, PH_RS_HI,
        PH_RS_FALL, PH_RS_END, PH_RX_LO, PH_RX_HI, PH_MACK_LO,
        PH_MACK_HI, PH_STOP_LO, PH_STOP_HI, PH_STOP_END
    } phase_t;

    phase_t      phase_reg;
    logic [3:0]  bit_count_reg;
    logic [7:0]  shift_reg;
    logic [2:0]  byte_index_reg;
    logic [7:0]  wait_count_reg;
    logic [2:0]  held_cmd_reg;
    logic [7:0]  held_reg_addr_reg;
    logic [15:0] held_wdata_reg;
    logic [15:0] read_buffer_reg;
    logic        error_reg;
    logic        res_valid_reg;
    res_word_t   res_word_reg;
    res_word_t   res_next;
    logic        is_read;
    logic        master_acks;
    logic        last_bit;
    logic [7:0]  rx_byte;
    tick_word_t  w;

    assign w           = head.word;
    assign pop         = head.valid && (!res_valid_reg || !res_stall);
    assign is_read     = (held_cmd_reg == CMD_READ_BYTE) || (held_cmd_reg == CMD_READ_WORD);
    assign master_acks = (held_cmd_reg == CMD_READ_WORD) && (byte_index_reg == 3'd3);
    assign last_bit    = (bit_count_reg >= 4'd7);
    assign rx_byte     = {shift_reg[6:0], w.sda_in};

    always_comb
    begin
        res_next.scl_out   = 1'b1;
        res_next.sda_out   = 1'b1;
        res_next.busy_res  = (phase_reg != PH_IDLE);
        res_next.done_res  = 1'b0;
        res_next.read_data = read_buffer_reg;
        res_next.ack_error = error_reg;
        unique case (phase_reg)
            PH_START_HI: res_next.sda_out = 1'b0;
            PH_START_LO:
            begin
                res_next.scl_out = 1'b0;
                res_next.sda_out = 1'b0;
            end
            PH_TX_LO:
            begin
                res_next.scl_out = 1'b0;
                res_next.sda_out = shift_reg[7];
            end
            PH_TX_HI: res_next.sda_out = shift_reg[7];
            PH_ACK_LO, PH_ACK_END, PH_RS_LO, PH_RX_LO: res_next.scl_out = 1'b0;
            PH_RS_FALL: res_next.sda_out = 1'b0;
            PH_RS_END, PH_STOP_LO:
            begin
                res_next.scl_out = 1'b0;
                res_next.sda_out = 1'b0;
            end
            PH_MACK_LO:
            begin
                res_next.scl_out = 1'b0;
                res_next.sda_out = !master_acks;
            end
            PH_MACK_HI: res_next.sda_out = !master_acks;
            PH_STOP_HI: res_next.sda_out = 1'b0;
            PH_STOP_END: res_next.done_res = 1'b1;
            default: res_next.scl_out = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            bit_count_reg     <= 4'd0;
            shift_reg         <= 8'd0;
            byte_index_reg    <= 3'd0;
            wait_count_reg    <= 8'd0;
            held_cmd_reg      <= CMD_NONE;
            held_reg_addr_reg <= 8'd0;
            held_wdata_reg    <= 16'd0;
            read_buffer_reg   <= 16'd0;
            error_reg         <= 1'b0;
            res_valid_reg     <= 1'b0;
            res_word_reg      <= '0;
        end
        else
        begin
            if (pop)
            begin
                res_valid_reg <= 1'b1;
                res_word_reg  <= res_next;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end

            if (pop)
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        if (w.cmd != CMD_NONE)
                        begin
                            held_cmd_reg      <= w.cmd;
                            held_reg_addr_reg <= w.reg_addr;
                            held_wdata_reg    <= w.wdata;
                            error_reg         <= 1'b0;
                            if (w.cmd == CMD_READ_BYTE || w.cmd == CMD_READ_WORD)
                            begin
                                read_buffer_reg <= 16'd0;
                            end
                            phase_reg <= PH_START_HI;
                        end
                    end
                    PH_START_HI: phase_reg <= PH_START_LO;
                    PH_START_LO:
                    begin
                        shift_reg      <= {cfg.device_address, 1'b0};
                        bit_count_reg  <= 4'd0;
                        byte_index_reg <= 3'd0;
                        phase_reg      <= PH_TX_LO;
                    end
                    PH_TX_LO: phase_reg <= PH_TX_HI;
                    PH_TX_HI:
                    begin
                        shift_reg     <= {shift_reg[6:0], 1'b0};
                        bit_count_reg <= bit_count_reg + 4'd1;
                        phase_reg     <= last_bit ? PH_ACK_LO : PH_TX_LO;
                    end
                    PH_ACK_LO:
                    begin
                        wait_count_reg <= 8'd0;
                        phase_reg      <= PH_ACK_HI;
                    end
                    PH_ACK_HI:
                    begin
                        if (!w.sda_in)
                        begin
                            phase_reg <= PH_ACK_END;
                        end
                        else if (wait_count_reg >= cfg.ack_timeout)
                        begin
                            error_reg <= 1'b1;
                            phase_reg <= PH_STOP_LO;
                        end
                        else
                        begin
                            wait_count_reg <= wait_count_reg + 8'd1;
                        end
                    end
                    PH_ACK_END:
                    begin
                        if (byte_index_reg == 3'd0)
                        begin
                            shift_reg      <= held_reg_addr_reg;
                            bit_count_reg  <= 4'd0;
                            byte_index_reg <= 3'd1;
                            phase_reg      <= PH_TX_LO;
                        end
                        else if (byte_index_reg == 3'd1)
                        begin
                            if (is_read)
                            begin
                                phase_reg <= PH_RS_LO;
                            end
                            else
                            begin
                                shift_reg <= (held_cmd_reg == CMD_WRITE_WORD) ?
                                             held_wdata_reg[15:8] : held_wdata_reg[7:0];
                                bit_count_reg  <= 4'd0;
                                byte_index_reg <= 3'd2;
                                phase_reg      <= PH_TX_LO;
                            end
                        end
                        else if (byte_index_reg == 3'd2)
                        begin
                            if (is_read)
                            begin
                                bit_count_reg  <= 4'd0;
                                shift_reg      <= 8'd0;
                                byte_index_reg <= 3'd3;
                                phase_reg      <= PH_RX_LO;
                            end
                            else if (held_cmd_reg == CMD_WRITE_WORD)
                            begin
                                shift_reg      <= held_wdata_reg[7:0];
                                bit_count_reg  <= 4'd0;
                                byte_index_reg <= 3'd3;
                                phase_reg      <= PH_TX_LO;
                            end
                            else
                            begin
                                phase_reg <= PH_STOP_LO;
                            end
                        end
                        else
                        begin
                            phase_reg <= PH_STOP_LO;
                        end
                    end
                    PH_RS_LO:   phase_reg <= PH_RS_HI;
                    PH_RS_HI:   phase_reg <= PH_RS_FALL;
                    PH_RS_FALL: phase_reg <= PH_RS_END;
                    PH_RS_END:
                    begin
                        shift_reg      <= {cfg.device_address, 1'b1};
                        bit_count_reg  <= 4'd0;
                        byte_index_reg <= 3'd2;
                        phase_reg      <= PH_TX_LO;
                    end
                    PH_RX_LO: phase_reg <= PH_RX_HI;
                    PH_RX_HI:
                    begin
                        shift_reg     <= rx_byte;
                        bit_count_reg <= bit_count_reg + 4'd1;
                        if (last_bit)
                        begin
                            if (master_acks)
                            begin
                                read_buffer_reg <= {rx_byte, 8'd0};
                            end
                            else
                            begin
                                read_buffer_reg <= {read_buffer_reg[15:8], rx_byte};
                            end
                            phase_reg <= PH_MACK_LO;
                        end
                        else
                        begin
                            phase_reg <= PH_RX_LO;
                        end
                    end
                    PH_MACK_LO: phase_reg <= PH_MACK_HI;
                    PH_MACK_HI:
                    begin
                        if (master_acks)
                        begin
                            bit_count_reg  <= 4'd0;
                            shift_reg      <= 8'd0;
                            byte_index_reg <= 3'd4;
                            phase_reg      <= PH_RX_LO;
                        end
                        else
                        begin
                            phase_reg <= PH_STOP_LO;
                        end
                    end
                    PH_STOP_LO: phase_reg <= PH_STOP_HI;
                    PH_STOP_HI: phase_reg <= PH_STOP_END;
                    default:
                    begin
                        phase_reg      <= PH_IDLE;
                        bit_count_reg  <= 4'd0;
                        byte_index_reg <= 3'd0;
                        wait_count_reg <= 8'd0;
                    end
                endcase
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

    a_done_follows_stop: assert property (@(posedge clk) disable iff (!rst_n)
        pop && phase_reg == PH_STOP_END |=> res_valid && res_word.done_res)
        else $error("stop completion not reported");

    a_error_from_ack: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(error_reg) |-> $past(phase_reg == PH_ACK_HI))
        else $error("error flag set outside acknowledge wait");

    a_bit_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bit_count_reg <= 4'd8)
        else $error("bit count out of range");

endmodule

FILE: hdl/i2c_register_access_master.sv
// ----------------------------------------------------------------------------
// I2C register access master: top level
// Bit-banged I2C master for device register reads and writes, one bus
// phase per tick word, with a small queue between intake and sequencer.
//
//   Channel  Handshake             Word
//   tick     tick_valid/stall      tick_word_t: cmd, reg_addr, wdata, sda_in
//   res      res_valid/stall       res_word_t: scl, sda, busy, done, data, error
//   cfg      cfg_valid/ready       cfg_index (0 address, 1 timeout), cfg_data
//
// One tick word is taken and one result word produced per cycle while res is not stalled.
// A taken tick word is written into the two-entry queue; once it is at the head
// and no result stall holds the sequencer, its result word is registered.
// Reset is ready at once; there is no clearing pass.
// A stalled result holds the sequencer; the queue then holds up to two words.
// ----------------------------------------------------------------------------
module i2c_register_access_master
    import i2cram_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       tick_valid,
    output logic       tick_stall,
    input  tick_word_t tick_word,
    output logic       res_valid,
    input  logic       res_stall,
    output res_word_t  res_word,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    cfg_t        cfg_reg;
    queue_head_t head;
    logic        pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_address <= DEVICE_ADDRESS_RESET;
            cfg_reg.ack_timeout    <= ACK_TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DEVICE_ADDRESS: cfg_reg.device_address <= cfg_data[6:0];
                CFG_ACK_TIMEOUT:    cfg_reg.ack_timeout    <= cfg_data;
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    i2cram_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_stall (tick_stall),
        .tick_word  (tick_word),
        .head       (head),
        .pop        (pop)
    );

    i2cram_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head      (head),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

endmodule

FILE: tb/i2cram_bus_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C register access master: bus sequence checker
// Watches the tick, result and configuration channels. Every accepted tick
// word is run through a cycle-true model of the bus sequencer, and the
// resulting line levels, status bits and read data are queued. Each accepted
// result word is then compared field by field with the oldest queued word.
// ----------------------------------------------------------------------------
module i2cram_bus_checker
    import i2cram_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       tick_valid,
    input  logic       tick_stall,
    input  tick_word_t tick_word,
    input  logic       res_valid,
    input  logic       res_stall,
    input  res_word_t  res_word,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    output int         fail_count,
    output int         outstanding,
    output int         ticks_taken,
    output int         results_seen,
    output int         transfers_done,
    output int         timeouts_seen,
    output logic       model_busy
);

    typedef enum logic [4:0] {
        S_IDLE, S_START_HI, S_START_LO, S_TX_LO, S_TX_HI, S_ACK_LO, S_ACK_HI,
        S_ACK_END, S_RS_LO, S_RS_HI, S_RS_FALL, S_RS_END, S_RX_LO, S_RX_HI,
        S_MACK_LO, S_MACK_HI, S_STOP_LO, S_STOP_HI, S_STOP_END
    } bus_phase_t;

    localparam logic [2:0] SLOT_ADDR_WRITE = 3'd0;
    localparam logic [2:0] SLOT_REGISTER   = 3'd1;
    localparam logic [2:0] SLOT_THIRD      = 3'd2;
    localparam logic [2:0] SLOT_RX_FIRST   = 3'd3;
    localparam logic [2:0] SLOT_RX_SECOND  = 3'd4;

    logic [6:0]  dev_addr;
    logic [7:0]  ack_limit;

    bus_phase_t  phase_q;
    logic [3:0]  bits_done;
    logic [7:0]  shreg;
    logic [2:0]  slot;
    logic [7:0]  ack_wait;
    logic [2:0]  cur_cmd;
    logic [7:0]  cur_reg;
    logic [15:0] cur_wdata;
    logic [15:0] rd_buf;
    logic        err_q;

    res_word_t   bus_levels_q[$];
    res_word_t   oldest;
    int          mismatches;
    int          n_ticks;
    int          n_results;
    int          n_done;
    int          n_timeouts;

    assign fail_count     = mismatches;
    assign outstanding    = n_ticks - n_results;
    assign ticks_taken    = n_ticks;
    assign results_seen   = n_results;
    assign transfers_done = n_done;
    assign timeouts_seen  = n_timeouts;
    assign model_busy     = (phase_q != S_IDLE);

    function automatic logic is_read_cmd();
        return cur_cmd == CMD_READ_BYTE || cur_cmd == CMD_READ_WORD;
    endfunction

    function automatic logic first_of_word();
        return cur_cmd == CMD_READ_WORD && slot == SLOT_RX_FIRST;
    endfunction

    function automatic void load_tx(logic [7:0] b, logic [2:0] idx);
        shreg     = b;
        bits_done = 4'd0;
        slot      = idx;
        phase_q   = S_TX_LO;
    endfunction

    function automatic res_word_t step_bus(tick_word_t t);
        res_word_t r;
        r = '0;
        r.scl_out = 1'b1;
        r.sda_out = 1'b1;
        case (phase_q)
            S_START_HI:  r.sda_out = 1'b0;
            S_START_LO:  begin r.scl_out = 1'b0; r.sda_out = 1'b0; end
            S_TX_LO:     begin r.scl_out = 1'b0; r.sda_out = shreg[7]; end
            S_TX_HI:     r.sda_out = shreg[7];
            S_ACK_LO,
            S_ACK_END,
            S_RS_LO,
            S_RX_LO:     r.scl_out = 1'b0;
            S_RS_FALL:   r.sda_out = 1'b0;
            S_RS_END,
            S_STOP_LO:   begin r.scl_out = 1'b0; r.sda_out = 1'b0; end
            S_MACK_LO:   begin r.scl_out = 1'b0; r.sda_out = !first_of_word(); end
            S_MACK_HI:   r.sda_out = !first_of_word();
            S_STOP_HI:   r.sda_out = 1'b0;
            default:     ;
        endcase
        r.busy_res  = (phase_q != S_IDLE);
        r.done_res  = (phase_q == S_STOP_END);
        r.read_data = rd_buf;
        r.ack_error = err_q;

        case (phase_q)
            S_IDLE:
                if (t.cmd >= CMD_READ_BYTE && t.cmd <= CMD_WRITE_WORD)
                begin
                    cur_cmd   = t.cmd;
                    cur_reg   = t.reg_addr;
                    cur_wdata = t.wdata;
                    err_q     = 1'b0;
                    if (t.cmd <= CMD_READ_WORD)
                        rd_buf = '0;
                    phase_q = S_START_HI;
                end
            S_START_HI: phase_q = S_START_LO;
            S_START_LO: load_tx({dev_addr, 1'b0}, SLOT_ADDR_WRITE);
            S_TX_LO:    phase_q = S_TX_HI;
            S_TX_HI:
            begin
                shreg     = shreg << 1;
                bits_done = bits_done + 4'd1;
                phase_q   = (bits_done >= 4'd8) ? S_ACK_LO : S_TX_LO;
            end
            S_ACK_LO:
            begin
                ack_wait = '0;
                phase_q  = S_ACK_HI;
            end
            S_ACK_HI:
                if (!t.sda_in)
                    phase_q = S_ACK_END;
                else if (ack_wait >= ack_limit)
                begin
                    err_q   = 1'b1;
                    phase_q = S_STOP_LO;
                    n_timeouts++;
                end
                else
                    ack_wait = ack_wait + 8'd1;
            S_ACK_END:
                if (slot == SLOT_ADDR_WRITE)
                    load_tx(cur_reg, SLOT_REGISTER);
                else if (slot == SLOT_REGISTER)
                begin
                    if (is_read_cmd())
                        phase_q = S_RS_LO;
                    else if (cur_cmd == CMD_WRITE_WORD)
                        load_tx(cur_wdata[15:8], SLOT_THIRD);
                    else
                        load_tx(cur_wdata[7:0], SLOT_THIRD);
                end
                else if (slot == SLOT_THIRD)
                begin
                    if (is_read_cmd())
                    begin
                        bits_done = 4'd0;
                        shreg     = '0;
                        slot      = SLOT_RX_FIRST;
                        phase_q   = S_RX_LO;
                    end
                    else if (cur_cmd == CMD_WRITE_WORD)
                        load_tx(cur_wdata[7:0], SLOT_RX_FIRST);
                    else
                        phase_q = S_STOP_LO;
                end
                else
                    phase_q = S_STOP_LO;
            S_RS_LO:    phase_q = S_RS_HI;
            S_RS_HI:    phase_q = S_RS_FALL;
            S_RS_FALL:  phase_q = S_RS_END;
            S_RS_END:   load_tx({dev_addr, 1'b1}, SLOT_THIRD);
            S_RX_LO:    phase_q = S_RX_HI;
            S_RX_HI:
            begin
                shreg     = {shreg[6:0], t.sda_in};
                bits_done = bits_done + 4'd1;
                if (bits_done >= 4'd8)
                begin
                    if (first_of_word())
                        rd_buf = {shreg, 8'h00};
                    else
                        rd_buf[7:0] = shreg;
                    phase_q = S_MACK_LO;
                end
                else
                    phase_q = S_RX_LO;
            end
            S_MACK_LO:  phase_q = S_MACK_HI;
            S_MACK_HI:
                if (first_of_word())
                begin
                    bits_done = 4'd0;
                    shreg     = '0;
                    slot      = SLOT_RX_SECOND;
                    phase_q   = S_RX_LO;
                end
                else
                    phase_q = S_STOP_LO;
            S_STOP_LO:  phase_q = S_STOP_HI;
            S_STOP_HI:  phase_q = S_STOP_END;
            default:
            begin
                phase_q   = S_IDLE;
                bits_done = 4'd0;
                slot      = SLOT_ADDR_WRITE;
                ack_wait  = '0;
                n_done++;
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr   = DEVICE_ADDRESS_RESET;
            ack_limit  = ACK_TIMEOUT_RESET;
            phase_q    = S_IDLE;
            bits_done  = '0;
            shreg      = '0;
            slot       = SLOT_ADDR_WRITE;
            ack_wait   = '0;
            cur_cmd    = CMD_NONE;
            cur_reg    = '0;
            cur_wdata  = '0;
            rd_buf     = '0;
            err_q      = 1'b0;
            bus_levels_q.delete();
            mismatches = 0;
            n_ticks    = 0;
            n_results  = 0;
            n_done     = 0;
            n_timeouts = 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (bus_levels_q.size() == 0)
                begin
                    $error("result word arrived with no tick word outstanding");
                    mismatches++;
                end
                else
                begin
                    oldest = bus_levels_q.pop_front();
                    n_results++;
                    check_field("scl_out", 16'(oldest.scl_out), 16'(res_word.scl_out));
                    check_field("sda_out", 16'(oldest.sda_out), 16'(res_word.sda_out));
                    check_field("busy_res", 16'(oldest.busy_res), 16'(res_word.busy_res));
                    check_field("done_res", 16'(oldest.done_res), 16'(res_word.done_res));
                    check_field("read_data", oldest.read_data, res_word.read_data);
                    check_field("ack_error", 16'(oldest.ack_error), 16'(res_word.ack_error));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_DEVICE_ADDRESS)
                    dev_addr = cfg_data[6:0];
                else
                    ack_limit = cfg_data;
            end
            if (tick_valid && !tick_stall)
            begin
                bus_levels_q.push_back(step_bus(tick_word));
                n_ticks++;
            end
        end
    end

endmodule

FILE: tb/i2c_register_access_master_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C register access master: testbench top
// Drives tick words, configuration writes and result back-pressure into the
// master, and leaves all prediction and comparison to the bus sequence
// checker. Directed transfers cover every command, data extremes, unused
// command codes and acknowledge timeouts; random phases then vary the device
// address, the timeout and the SDA bias under changing idle patterns.
// ----------------------------------------------------------------------------
module i2c_register_access_master_tb;
    import i2cram_pkg::*;

    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_TICKS = 40;

    logic       clk;
    logic       rst_n;
    logic       tick_valid;
    logic       tick_stall;
    tick_word_t tick_word;
    logic       res_valid;
    logic       res_stall;
    res_word_t  res_word;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_index;
    logic [7:0] cfg_data;

    int   tx_idle_pct;
    int   rx_idle_pct;
    int   sda_low_pct;
    logic hold_request;
    int   quiet_cycles = 0;

    int   fail_count;
    int   outstanding;
    int   ticks_taken;
    int   results_seen;
    int   transfers_done;
    int   timeouts_seen;
    logic model_busy;

    i2c_register_access_master dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_stall (tick_stall),
        .tick_word  (tick_word),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_word   (res_word),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    i2cram_bus_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .tick_valid     (tick_valid),
        .tick_stall     (tick_stall),
        .tick_word      (tick_word),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .res_word       (res_word),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .outstanding    (outstanding),
        .ticks_taken    (ticks_taken),
        .results_seen   (results_seen),
        .transfers_done (transfers_done),
        .timeouts_seen  (timeouts_seen),
        .model_busy     (model_busy)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The receiver either stalls at random or, on request, holds off for a
    // long stretch so that the queue fills and the tick channel stalls.
    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_request = 1'b0;
            end
            else
                res_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (tick_valid && !tick_stall) || (res_valid && !res_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic tick_word_t make_tick(logic [2:0] c, logic [7:0] r, logic [15:0] d);
        tick_word_t t;
        t.cmd      = c;
        t.reg_addr = r;
        t.wdata    = d;
        t.sda_in   = ($urandom_range(0, 99) >= sda_low_pct);
        return t;
    endfunction

    function automatic tick_word_t random_tick();
        logic [2:0]  c;
        logic [15:0] d;
        if ($urandom_range(0, 9) < 7)
            c = 3'($urandom_range(CMD_READ_BYTE, CMD_WRITE_WORD));
        else
            c = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 7) == 0)
            d = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        else
            d = 16'($urandom);
        return make_tick(c, 8'($urandom), d);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_tick(input tick_word_t w);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            tick_valid <= 1'b0;
            @(negedge clk);
        end
        tick_valid <= 1'b1;
        tick_word  <= w;
        do @(posedge clk); while (tick_stall);
        @(negedge clk);
    endtask

    task automatic run_transfer(input logic [2:0] c, input logic [7:0] r, input logic [15:0] d);
        send_tick(make_tick(c, r, d));
        while (model_busy)
            send_tick(random_tick());
    endtask

    // Finishes any transfer with prompt acknowledges and waits for the
    // result channel to catch up, leaving the master idle.
    task automatic settle();
        int saved_low;
        saved_low   = sda_low_pct;
        sda_low_pct = 100;
        while (model_busy)
            send_tick(make_tick(CMD_NONE, 8'h00, 16'h0000));
        sda_low_pct = saved_low;
        tick_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic configure(input logic [7:0] dev, input logic [7:0] tmo);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_DEVICE_ADDRESS;
        cfg_data  <= dev;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_index <= CFG_ACK_TIMEOUT;
        cfg_data  <= tmo;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input logic [7:0] dev, input logic [7:0] tmo,
                                input int low_pct, input bit with_hold);
        settle();
        configure(dev, tmo);
        sda_low_pct = low_pct;
        if (with_hold)
            hold_request = 1'b1;
        repeat (PHASE_TICKS)
            send_tick(random_tick());
    endtask

    initial
    begin
        rst_n        = 1'b0;
        tick_valid   = 1'b0;
        tick_word    = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_DEVICE_ADDRESS;
        cfg_data     = '0;
        hold_request = 1'b0;
        tx_idle_pct  = 16;
        rx_idle_pct  = 87;
        sda_low_pct  = 100;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_transfer(CMD_READ_BYTE, 8'h00, 16'h0000);
        run_transfer(CMD_READ_WORD, 8'hFF, 16'hFFFF);
        run_transfer(CMD_WRITE_BYTE, 8'hA5, 16'hFFFF);
        run_transfer(CMD_WRITE_WORD, 8'h5A, 16'h0000);
        run_transfer(CMD_WRITE_WORD, 8'hFF, 16'hFFFF);
        sda_low_pct = 50;
        run_transfer(CMD_READ_WORD, 8'h3C, 16'h8001);
        for (int c = int'(CMD_WRITE_WORD) + 1; c < 8; c++)
            send_tick(make_tick(3'(c), 8'hFF, 16'hFFFF));
        send_tick(make_tick(CMD_NONE, 8'h00, 16'h0000));
        sda_low_pct = 0;
        run_transfer(CMD_WRITE_BYTE, 8'h81, 16'h1234);

        settle();
        configure(8'h00, 8'h00);
        run_transfer(CMD_READ_WORD, 8'h10, 16'h0000);
        sda_low_pct = 100;
        run_transfer(CMD_WRITE_WORD, 8'h20, 16'hC3C3);
        settle();
        configure(8'hFF, 8'hFF);
        sda_low_pct = 50;
        run_transfer(CMD_READ_BYTE, 8'h7E, 16'h0000);

        for (int p = 0; p < 3; p++)
        begin
            settle();
            tx_idle_pct = (p == 0) ? 16 : (p == 1) ? 87 : 0;
            rx_idle_pct = (p == 0) ? 87 : (p == 1) ? 16 : 0;
            random_phase(8'($urandom), 8'($urandom_range(1, 255)), 50, 1'b0);
            random_phase((p == 1) ? 8'h7F : 8'h00, 8'($urandom_range(0, 3)), 25, 1'b0);
            random_phase(8'($urandom), 8'hFF, 50, p == 2);
        end

        settle();
        repeat (10) @(posedge clk);
        $display("Run covered %0d tick words and %0d result words in %0d transfers.",
                 ticks_taken, results_seen, transfers_done);
        $display("%0d transfers ended on acknowledge timeout; idle patterns and a hold-off varied.",
                 timeouts_seen);
        if (fail_count == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: files.f
hdl/i2cram_pkg.sv
hdl/i2cram_front.sv
hdl/i2cram_back.sv
hdl/i2c_register_access_master.sv
tb/i2cram_bus_checker.sv
tb/i2c_register_access_master_tb.sv
